// ----- rtl/grpc_pkg.sv -----
// grpc_pkg: sizes, codes and transaction types for the greedy radius point clustering unit
// no dependencies; imported by the top level unit and by grpc_dist
`default_nettype none

package grpc_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 16;

  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int XY_W       = 2 * COORD_BITS;
  localparam int RADIUS_W   = 16;
  localparam int R2_W       = 2 * RADIUS_W;
  localparam int DIST_W     = 2 * COORD_BITS + 1;
  localparam int CMP_W      = (DIST_W > R2_W) ? DIST_W : R2_W;
  localparam int SECTOR_W   = 6;
  localparam int SECT_CNT_W = 7;
  localparam int KIND_W     = 2;
  localparam int SLOT_W     = SECTOR_W + KIND_W;
  localparam int DIST_LAT   = 4;
  localparam int PIPE_LAT   = DIST_LAT + 1;
  localparam int DRAIN_W    = $clog2(PIPE_LAT);

  typedef enum logic [KIND_W-1:0] {
    KIND_NOISE  = 2'd0,
    KIND_CORE   = 2'd1,
    KIND_BORDER = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COUNT,
    ST_CNT_DRAIN,
    ST_DECIDE,
    ST_ASSIGN,
    ST_ASN_DRAIN,
    ST_CORE,
    ST_NOISE,
    ST_OUT_RD,
    ST_OUT_LOAD
  } state_t;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic [5:0] point_index;
    logic [5:0] sector_id;
    logic [1:0] point_kind;
    logic       last_result;
  } out_item_t;

  // travels alongside one point pair through the distance pipeline
  typedef struct packed {
    logic             valid;
    logic             assign_mode;
    logic             elig;
    logic             lastj;
    logic [IDX_W-1:0] ref_idx;
    logic [IDX_W-1:0] cand_idx;
  } pair_tag_t;

endpackage

`default_nettype wire

// ----- rtl/greedy_radius_point_clustering_unit.sv -----
// greedy radius point clustering unit: loads a batch of points, clusters, streams results
// points load back to back while idle; the neighbour counts and assignments of each round
// run on the single pair distance pipeline that evaluates one point pair per cycle
// each result takes a slot RAM read state and then a load state that waits for a free
// output register; not ready for input during clustering
// reset: rst_n synchronous active low, clears radius, batch counters and assigned flags
`default_nettype none

module greedy_radius_point_clustering_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire grpc_pkg::in_item_t            in_data,
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      grpc_pkg::out_item_t           out_data,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [grpc_pkg::RADIUS_W-1:0] cfg_data
);
  import grpc_pkg::*;

  state_t                  state_r, state_nxt;
  logic [RADIUS_W-1:0]     radius_r;
  logic [R2_W-1:0]         r2_r;
  logic [IDX_W-1:0]        load_idx_r, last_idx_r;
  logic [IDX_W-1:0]        i_r, j_r, k_r, best_idx_r;
  logic [CNT_W-1:0]        cnt_r, best_cnt_r, cnt_sum;
  logic [SECT_CNT_W-1:0]   next_sector_r;
  logic [MAX_POINTS-1:0]   assigned_r;
  logic [DRAIN_W-1:0]      drain_r;
  pair_tag_t               tag_r, tag_issue, res_tag;
  logic                    res_near;
  logic                    out_valid_r;
  out_item_t               out_data_r;

  logic                    in_fire, close_batch, drain_done, out_free;
  logic [XY_W-1:0]         load_xy, ref_q, cand_q;
  logic [IDX_W-1:0]        ref_addr;
  logic                    slot_we;
  logic [IDX_W-1:0]        slot_waddr;
  logic [SLOT_W-1:0]       slot_wdata, slot_q;
  logic                    border_hit;

  assign in_fire     = in_valid && in_ready;
  assign close_batch = in_data.last_point || (load_idx_r == IDX_W'(MAX_POINTS - 1));
  assign drain_done  = drain_r == DRAIN_W'(PIPE_LAT - 1);
  assign out_free    = !out_valid_r || out_ready;
  assign load_xy     = {COORD_BITS'(in_data.point_x), COORD_BITS'(in_data.point_y)};
  assign border_hit  = res_tag.valid && res_tag.assign_mode && res_tag.elig && res_near;
  assign cnt_sum     = cnt_r + CNT_W'(res_tag.elig && res_near);
  // radius only changes in the idle state, never during clustering or output
  assign cfg_ready   = state_r == ST_IDLE;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_fire && close_batch) state_nxt = ST_COUNT;
      ST_COUNT: begin
        if (i_r == last_idx_r && (assigned_r[i_r] || j_r == last_idx_r)) begin
          state_nxt = ST_CNT_DRAIN;
        end
      end
      ST_CNT_DRAIN: if (drain_done) state_nxt = ST_DECIDE;
      ST_DECIDE:    state_nxt = (best_cnt_r == '0) ? ST_NOISE : ST_ASSIGN;
      ST_ASSIGN:    if (j_r == last_idx_r) state_nxt = ST_ASN_DRAIN;
      ST_ASN_DRAIN: if (drain_done) state_nxt = ST_CORE;
      ST_CORE:      state_nxt = ST_COUNT;
      ST_NOISE:     if (j_r == last_idx_r) state_nxt = ST_OUT_RD;
      ST_OUT_RD:    state_nxt = ST_OUT_LOAD;
      ST_OUT_LOAD: begin
        if (out_free) begin
          state_nxt = (k_r == last_idx_r) ? ST_IDLE : ST_OUT_RD;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready              = 1'b0;
    tag_issue             = '0;
    tag_issue.ref_idx     = i_r;
    tag_issue.cand_idx    = j_r;
    tag_issue.lastj       = j_r == last_idx_r;
    slot_we               = border_hit;
    slot_waddr            = res_tag.cand_idx;
    slot_wdata            = {next_sector_r[SECTOR_W-1:0], KIND_BORDER};
    unique case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_COUNT: begin
        tag_issue.valid = !assigned_r[i_r];
        tag_issue.elig  = (j_r != i_r) && !assigned_r[j_r];
      end
      ST_ASSIGN: begin
        tag_issue.valid       = 1'b1;
        tag_issue.assign_mode = 1'b1;
        tag_issue.ref_idx     = best_idx_r;
        tag_issue.elig        = (j_r != best_idx_r) && !assigned_r[j_r];
      end
      ST_CORE: begin
        slot_we    = 1'b1;
        slot_waddr = best_idx_r;
        slot_wdata = {next_sector_r[SECTOR_W-1:0], KIND_CORE};
      end
      ST_NOISE: begin
        slot_we    = !assigned_r[j_r];
        slot_waddr = j_r;
        slot_wdata = {next_sector_r[SECTOR_W-1:0], KIND_NOISE};
      end
      default: ;
    endcase
    ref_addr = tag_issue.ref_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      radius_r <= '0;
      r2_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        radius_r <= cfg_data;
      end
      r2_r <= R2_W'(radius_r) * R2_W'(radius_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_idx_r    <= '0;
      last_idx_r    <= '0;
      next_sector_r <= '0;
      assigned_r    <= '0;
      i_r           <= '0;
      j_r           <= '0;
      k_r           <= '0;
      cnt_r         <= '0;
      best_cnt_r    <= '0;
      best_idx_r    <= '0;
      drain_r       <= '0;
      tag_r.valid   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      tag_r <= tag_issue;

      if (state_r == ST_CNT_DRAIN || state_r == ST_ASN_DRAIN) begin
        drain_r <= drain_r + 1'b1;
      end else begin
        drain_r <= '0;
      end

      if (in_fire) begin
        if (close_batch) begin
          load_idx_r    <= '0;
          last_idx_r    <= load_idx_r;
          next_sector_r <= '0;
          assigned_r    <= '0;
        end else begin
          load_idx_r <= load_idx_r + 1'b1;
        end
      end

      // a new round starts from a clean search
      if (state_nxt == ST_COUNT && state_r != ST_COUNT) begin
        i_r        <= '0;
        j_r        <= '0;
        cnt_r      <= '0;
        best_cnt_r <= '0;
        best_idx_r <= '0;
      end

      unique case (state_r)
        ST_COUNT: begin
          if (assigned_r[i_r] || j_r == last_idx_r) begin
            i_r <= i_r + 1'b1;
            j_r <= '0;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        ST_DECIDE: j_r <= '0;
        ST_ASSIGN: j_r <= j_r + 1'b1;
        ST_CORE: begin
          assigned_r[best_idx_r] <= 1'b1;
          next_sector_r          <= next_sector_r + 1'b1;
        end
        ST_NOISE: begin
          j_r <= j_r + 1'b1;
          k_r <= '0;
          if (!assigned_r[j_r]) begin
            next_sector_r <= next_sector_r + 1'b1;
          end
        end
        default: ;
      endcase

      // results coming out of the distance pipeline
      if (res_tag.valid) begin
        if (res_tag.assign_mode) begin
          if (border_hit) begin
            assigned_r[res_tag.cand_idx] <= 1'b1;
          end
        end else if (res_tag.lastj) begin
          cnt_r <= '0;
          if (cnt_sum > best_cnt_r) begin
            best_cnt_r <= cnt_sum;
            best_idx_r <= res_tag.ref_idx;
          end
        end else begin
          cnt_r <= cnt_sum;
        end
      end

      if (state_r == ST_OUT_LOAD && out_free) begin
        out_valid_r <= 1'b1;
        k_r         <= k_r + 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT_LOAD && out_free) begin
      out_data_r.point_index <= 6'(k_r);
      out_data_r.sector_id   <= slot_q[SLOT_W-1:KIND_W];
      out_data_r.point_kind  <= slot_q[KIND_W-1:0];
      out_data_r.last_result <= k_r == last_idx_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // two copies of the coordinates so a reference and a candidate read each cycle
  grpc_ram #(
    .WIDTH (XY_W),
    .DEPTH (MAX_POINTS)
  ) u_ref_ram (
    .clk   (clk),
    .we    (in_fire),
    .waddr (load_idx_r),
    .wdata (load_xy),
    .raddr (ref_addr),
    .rdata (ref_q)
  );

  grpc_ram #(
    .WIDTH (XY_W),
    .DEPTH (MAX_POINTS)
  ) u_cand_ram (
    .clk   (clk),
    .we    (in_fire),
    .waddr (load_idx_r),
    .wdata (load_xy),
    .raddr (j_r),
    .rdata (cand_q)
  );

  grpc_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_POINTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (k_r),
    .rdata (slot_q)
  );

  grpc_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .ref_xy  (ref_q),
    .cand_xy (cand_q),
    .tag_in  (tag_r),
    .r2      (r2_r),
    .tag_out (res_tag),
    .near    (res_near)
  );

endmodule

`default_nettype wire

// ----- rtl/grpc_ram.sv -----
// grpc_ram: generic single write port, single read port RAM with registered read
// no dependencies
`default_nettype none

module grpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- rtl/grpc_dist.sv -----
// grpc_dist: pipelined squared distance compare for one point pair per cycle
// depends on grpc_pkg
`default_nettype none

module grpc_dist (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [grpc_pkg::XY_W-1:0]  ref_xy,
  input  wire logic [grpc_pkg::XY_W-1:0]  cand_xy,
  input  wire grpc_pkg::pair_tag_t        tag_in,
  input  wire logic [grpc_pkg::R2_W-1:0]  r2,
  output      grpc_pkg::pair_tag_t        tag_out,
  output      logic                       near
);
  import grpc_pkg::*;

  logic signed [COORD_BITS:0] dx, dy;
  logic        [COORD_BITS:0] dx_abs, dy_abs;
  logic        [CMP_W-1:0]    dsum;

  pair_tag_t                  s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r;
  logic [COORD_BITS-1:0]      s1_ax_r, s1_ay_r, s2_ay_r;
  logic [2*COORD_BITS-1:0]    s2_sqx_r, s3_sqx_r, s3_sqy_r;
  logic                       s4_near_r;

  // coordinates are packed x high, y low
  always_comb begin
    dx = $signed({ref_xy[XY_W-1], ref_xy[XY_W-1:COORD_BITS]})
       - $signed({cand_xy[XY_W-1], cand_xy[XY_W-1:COORD_BITS]});
    dy = $signed({ref_xy[COORD_BITS-1], ref_xy[COORD_BITS-1:0]})
       - $signed({cand_xy[COORD_BITS-1], cand_xy[COORD_BITS-1:0]});
    dx_abs = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
    dy_abs = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
    dsum   = CMP_W'(s3_sqx_r) + CMP_W'(s3_sqy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r.valid <= 1'b0;
      s2_tag_r.valid <= 1'b0;
      s3_tag_r.valid <= 1'b0;
      s4_tag_r.valid <= 1'b0;
    end else begin
      s1_tag_r <= tag_in;
      s2_tag_r <= s1_tag_r;
      s3_tag_r <= s2_tag_r;
      s4_tag_r <= s3_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ax_r   <= dx_abs[COORD_BITS-1:0];
    s1_ay_r   <= dy_abs[COORD_BITS-1:0];
    s2_sqx_r  <= XY_W'(s1_ax_r) * XY_W'(s1_ax_r);
    s2_ay_r   <= s1_ay_r;
    s3_sqx_r  <= s2_sqx_r;
    s3_sqy_r  <= XY_W'(s2_ay_r) * XY_W'(s2_ay_r);
    s4_near_r <= dsum < CMP_W'(r2);
  end

  assign tag_out = s4_tag_r;
  assign near    = s4_near_r;

endmodule

`default_nettype wire
